>>> hw/rtl/mma_pkg.sv
`default_nettype none

package mma_pkg;

   // Window length and number of channels.
   localparam int WINDOW   = 16;
   localparam int CHANNELS = 4;

   // Field widths of the beats.
   localparam int CHAN_W   = 2;
   localparam int SAMPLE_W = 12;

   // Derived storage widths.
   localparam int IDX_W      = $clog2(WINDOW);
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
   localparam int CIDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W     = CIDX_W + IDX_W;
   localparam int RAM_DEPTH  = 1 << ADDR_W;

   // Divider: quotient bits resolved per cycle and cycles per quotient.
   localparam int DIV_STEP   = 6;
   localparam int DIV_CYCLES = SAMPLE_W / DIV_STEP;
   localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int DSH_W      = CNT_W + SAMPLE_W - 1;
   localparam int CMP_W      = (SUM_W > DSH_W) ? SUM_W : DSH_W;

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] sample;
   } mma_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   out_channel;
      logic [SAMPLE_W-1:0] average;
   } mma_rsp_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic out_load;
   } mma_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/mma_ram.sv
`default_nettype none

module mma_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/mma_div.sv
`default_nettype none

module mma_div (
   input  wire logic                    clock,
   input  wire logic                    start,
   input  wire logic                    step,
   input  wire logic [mma_pkg::SUM_W-1:0] num,
   input  wire logic [mma_pkg::CNT_W-1:0] den,
   output logic      [mma_pkg::SAMPLE_W-1:0] quot
);

   import mma_pkg::*;

   logic [SUM_W-1:0]    rem_ff;
   logic [SUM_W-1:0]    rem_in;
   logic [DSH_W-1:0]    dsh_ff;
   logic [DSH_W-1:0]    dsh_in;
   logic [SAMPLE_W-1:0] quot_ff;
   logic [SAMPLE_W-1:0] quot_in;

   // The quotient is known to fit in SAMPLE_W bits, so the divisor starts
   // aligned to the top quotient bit and moves down one place per quotient bit.
   always_comb begin
      logic [CMP_W-1:0]    r;
      logic [CMP_W-1:0]    d;
      logic [SAMPLE_W-1:0] q;
      r = CMP_W'(rem_ff);
      d = CMP_W'(dsh_ff);
      q = quot_ff;
      for (int j = 0; j < DIV_STEP; j++) begin
         if (r >= d) begin
            r = r - d;
            q = {q[SAMPLE_W-2:0], 1'b1};
         end else begin
            q = {q[SAMPLE_W-2:0], 1'b0};
         end
         d = d >> 1;
      end
      rem_in  = r[SUM_W-1:0];
      dsh_in  = d[DSH_W-1:0];
      quot_in = q;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= num;
         dsh_ff  <= DSH_W'(den) << (SAMPLE_W - 1);
         quot_ff <= '0;
      end else if (step) begin
         rem_ff  <= rem_in;
         dsh_ff  <= dsh_in;
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mma_datapath.sv
`default_nettype none

module mma_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mma_pkg::mma_cmd_type cmd_i,
   input  wire mma_pkg::mma_req_type req_payload,
   output mma_pkg::mma_rsp_type      rsp_payload
);

   import mma_pkg::*;

   logic [SUM_W-1:0]    sum_ff  [CHANNELS];
   logic [IDX_W-1:0]    widx_ff [CHANNELS];
   logic [CNT_W-1:0]    fill_ff [CHANNELS];

   logic [CHAN_W-1:0]   item_ch_ff;
   logic [SAMPLE_W-1:0] item_smp_ff;
   logic                item_present_ff;
   mma_rsp_type         rsp_ff;

   logic [CIDX_W-1:0]   req_cidx;
   logic [CIDX_W-1:0]   cidx;
   logic                req_present;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic [SAMPLE_W-1:0] old_smp;
   logic [SUM_W-1:0]    sum_in;
   logic [IDX_W-1:0]    widx_in;
   logic [CNT_W-1:0]    fill_in;
   logic [SUM_W-1:0]    div_num;
   logic [CNT_W-1:0]    div_den;
   logic [SAMPLE_W-1:0] div_quot;

   assign req_cidx    = CIDX_W'(req_payload.channel);
   assign req_present = 32'(req_payload.channel) < 32'(CHANNELS);
   assign cidx        = CIDX_W'(item_ch_ff);

   // The ring is filled in order from slot zero, so until the window is full
   // the slot about to be overwritten has never been written and counts as zero.
   assign old_smp = (fill_ff[cidx] == CNT_W'(WINDOW)) ? ram_rd_data : '0;
   assign sum_in  = sum_ff[cidx] - SUM_W'(old_smp) + SUM_W'(item_smp_ff);
   assign widx_in = (widx_ff[cidx] == IDX_W'(WINDOW - 1)) ? '0 : widx_ff[cidx] + 1'b1;
   assign fill_in = (fill_ff[cidx] == CNT_W'(WINDOW)) ? fill_ff[cidx] : fill_ff[cidx] + 1'b1;

   assign div_num = item_present_ff ? sum_in  : '0;
   assign div_den = item_present_ff ? fill_in : CNT_W'(1);

   mma_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd_i.update && item_present_ff),
      .wr_addr ({cidx, widx_ff[cidx]}),
      .wr_data (item_smp_ff),
      .rd_en   (cmd_i.capture),
      .rd_addr ({req_cidx, widx_ff[req_cidx]}),
      .rd_data (ram_rd_data)
   );

   mma_div u_div (
      .clock (clock),
      .start (cmd_i.update),
      .step  (cmd_i.div_step),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c]  <= '0;
            widx_ff[c] <= '0;
            fill_ff[c] <= '0;
         end
      end else if (cmd_i.update && item_present_ff) begin
         sum_ff[cidx]  <= sum_in;
         widx_ff[cidx] <= widx_in;
         fill_ff[cidx] <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         item_ch_ff      <= req_payload.channel;
         item_smp_ff     <= req_payload.sample;
         item_present_ff <= req_present;
      end
      if (cmd_i.out_load) begin
         rsp_ff.out_channel <= item_ch_ff;
         rsp_ff.average     <= div_quot;
      end
   end

   assign rsp_payload = rsp_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd_i.update && item_present_ff |-> fill_ff[cidx] <= CNT_W'(WINDOW))
      else $error("fill count ran past the window length");

   a_index_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      cmd_i.update && item_present_ff && fill_ff[cidx] != CNT_W'(WINDOW)
      |-> CNT_W'(widx_ff[cidx]) == fill_ff[cidx])
      else $error("write index left the fill count during warm-up");

endmodule

`default_nettype wire

>>> hw/rtl/mma_ctrl.sv
`default_nettype none

module mma_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output mma_pkg::mma_cmd_type cmd_o
);

   import mma_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic              rsp_valid_ff;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd_o          = '0;
      cmd_o.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd_o.update   = (state_ff == ST_UPDATE);
      cmd_o.div_step = (state_ff == ST_DIVIDE);
      cmd_o.out_load = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               dcnt_ff  <= '0;
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (dcnt_ff == DCNT_W'(DIV_CYCLES - 1)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  dcnt_ff <= dcnt_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_UPDATE)
      else $error("accepted beat did not start an update");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd_o.out_load |-> out_free)
      else $error("result loaded over a beat not yet taken");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");

   a_finish_after_divide: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_FINISH) |-> $past(state_ff == ST_DIVIDE))
      else $error("finish reached without a full divide");

endmodule

`default_nettype wire

>>> hw/rtl/multichannel_moving_average.sv
`default_nettype none

// Per-channel boxcar moving average of 12-bit converter samples. Each request
// beat carries a channel and a sample; each produces exactly one response beat
// with the channel echoed and the truncated mean of that channel's samples so
// far (up to the last WINDOW of them). One beat is in work at a time: a new
// request is taken only once the response of the last one is loaded. Each
// beat passes through the ring RAM read, its write-back and the divider,
// which resolves six quotient bits per cycle. A finished response waits in
// its own register, so the next request is accepted even while the response
// side stalls. No clearing pass runs after reset: the per-channel fill count
// stands in for the cleared ring.
module multichannel_moving_average (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mma_pkg::mma_req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mma_pkg::mma_rsp_type      rsp_payload
);

   import mma_pkg::*;

   mma_cmd_type cmd;

   mma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd_o     (cmd)
   );

   mma_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd_i       (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
